[hw/rtl/port_free_list_allocator_defines.svh]
// ----------------------------------------------------------------------------
// port free list allocator assertion macros
// shared checks written against clk and rst_n of the including module
// ----------------------------------------------------------------------------
`ifndef PORT_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define PORT_FREE_LIST_ALLOCATOR_DEFINES_SVH

// invariant that holds at every edge out of reset
`define PFLA_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequence in the cycle after a condition
`define PFLA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/pfla_pkg.sv]
// ----------------------------------------------------------------------------
// pfla_pkg
// shared types and codes of the port free list allocator
// ----------------------------------------------------------------------------
package pfla_pkg;

  localparam int PORT_W  = 16;
  localparam int REQ_W   = 2;
  localparam int FCNT_W  = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd0;
  localparam logic [REQ_W-1:0] REQ_GET   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_GIVE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 1'd1;

  localparam logic [PORT_W-1:0] RANGE_LOW_RST  = 16'd1;
  localparam logic [PORT_W-1:0] RANGE_HIGH_RST = 16'd0;

  typedef struct packed {
    logic refill;
    logic exec;
  } pfla_cmd_t;

endpackage

[hw/rtl/port_free_list_allocator.sv]
// ----------------------------------------------------------------------------
// port_free_list_allocator
// fifo free list of port numbers with query, get and give-back requests
// ----------------------------------------------------------------------------
// One request item is taken per clock cycle while busy is low; its result is
// on the out_ ports for exactly one cycle, marked by out_valid, in the cycle
// after acceptance, since the read of the port memory is registered.
// Results cannot be held off. Busy is high for one cycle after reset while
// the list is loaded. A range register write reloads the list in that same
// cycle: loaded ports are produced from the range bounds, so the memory
// needs no clearing pass and only holds ports given back.
module port_free_list_allocator #(
  parameter int DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [pfla_pkg::REQ_W-1:0]     in_req_type,
  input  logic [pfla_pkg::PORT_W-1:0]    in_port_value,
  input  logic [pfla_pkg::PORT_W-1:0]    in_ports_wanted,
  output logic                           out_valid,
  output logic                           out_ok,
  output logic [pfla_pkg::PORT_W-1:0]    out_port_out,
  output logic [pfla_pkg::FCNT_W-1:0]    out_free_count,
  input  logic                           cfg_we,
  input  logic [pfla_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pfla_pkg::PORT_W-1:0]    cfg_wdata
);
  import pfla_pkg::*;

  pfla_cmd_t cmd;

  pfla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  pfla_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_req_type     (in_req_type),
    .in_port_value   (in_port_value),
    .in_ports_wanted (in_ports_wanted),
    .out_ok          (out_ok),
    .out_port_out    (out_port_out),
    .out_free_count  (out_free_count)
  );

endmodule

[hw/rtl/pfla_ctrl.sv]
// ----------------------------------------------------------------------------
// pfla_ctrl
// request sequencer: loads the list after reset, then takes one item a cycle
// ----------------------------------------------------------------------------
module pfla_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output logic             out_valid,
  output pfla_pkg::pfla_cmd_t cmd
);
  import pfla_pkg::*;

  localparam logic ST_INIT = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: state_nxt = ST_RUN;
      ST_RUN:  state_nxt = ST_RUN;
      default: state_nxt = ST_INIT;
    endcase
  end

  assign busy          = (state_r != ST_RUN);
  assign cmd.refill    = (state_r == ST_INIT);
  assign cmd.exec      = start && !busy;
  assign out_valid_nxt = cmd.exec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[hw/rtl/pfla_datapath.sv]
// ----------------------------------------------------------------------------
// pfla_datapath
// ring buffer of free ports, range registers and result registers
// ----------------------------------------------------------------------------
module pfla_datapath #(
  parameter int DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pfla_pkg::pfla_cmd_t               cmd,
  input  logic                              cfg_we,
  input  logic [pfla_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pfla_pkg::PORT_W-1:0]       cfg_wdata,
  input  logic [pfla_pkg::REQ_W-1:0]        in_req_type,
  input  logic [pfla_pkg::PORT_W-1:0]       in_port_value,
  input  logic [pfla_pkg::PORT_W-1:0]       in_ports_wanted,
  output logic                              out_ok,
  output logic [pfla_pkg::PORT_W-1:0]       out_port_out,
  output logic [pfla_pkg::FCNT_W-1:0]       out_free_count
);
  import pfla_pkg::*;

  `include "port_free_list_allocator_defines.svh"

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int SW   = PORT_W + 1;
  localparam int CMPW = (CW > PORT_W) ? CW : PORT_W;

  logic [PORT_W-1:0] mem [DEPTH];
  logic [PORT_W-1:0] mem_q_r;

  logic [PORT_W-1:0] low_r, low_nxt, high_r, high_nxt;
  logic [AW-1:0]     head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0]     count_r, count_nxt, left_r, left_nxt;

  logic              ok_r, ok_nxt;
  logic              sel_mem_r, sel_mem_nxt;
  logic [PORT_W-1:0] range_port_r, range_port_nxt;
  logic [FCNT_W-1:0] fcnt_r, fcnt_nxt;

  logic              refill;
  logic [SW-1:0]     span, size;
  logic [CW-1:0]     fill_n;
  logic              push_en, pop_en;
  logic              is_get, is_give, is_query;
  logic [AW-1:0]     head_inc, tail_inc;

  assign refill   = cmd.refill || cfg_we;
  assign is_query = (in_req_type == REQ_QUERY);
  assign is_get   = (in_req_type == REQ_GET);
  assign is_give  = (in_req_type == REQ_GIVE);
  assign pop_en   = cmd.exec && is_get && (count_r != '0);
  assign push_en  = cmd.exec && is_give && (count_r != CW'(DEPTH));
  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + 1'b1;

  always_comb begin
    low_nxt  = low_r;
    high_nxt = high_r;
    if (cfg_we && (cfg_index == CFG_RANGE_LOW)) begin
      low_nxt = cfg_wdata;
    end
    if (cfg_we && (cfg_index == CFG_RANGE_HIGH)) begin
      high_nxt = cfg_wdata;
    end
  end

  // range size, capped at the list depth, zero when high is below low
  assign span = {1'b0, high_nxt} - {1'b0, low_nxt};
  assign size = span + 1'b1;
  always_comb begin
    fill_n = '0;
    if (high_nxt >= low_nxt) begin
      fill_n = (size > SW'(DEPTH)) ? CW'(DEPTH) : CW'(size);
    end
  end

  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    left_nxt       = left_r;
    ok_nxt         = ok_r;
    sel_mem_nxt    = sel_mem_r;
    range_port_nxt = range_port_r;
    if (refill) begin
      head_nxt  = '0;
      tail_nxt  = (fill_n == CW'(DEPTH)) ? '0 : AW'(fill_n);
      count_nxt = fill_n;
      left_nxt  = fill_n;
    end else if (cmd.exec) begin
      ok_nxt         = 1'b0;
      sel_mem_nxt    = 1'b0;
      range_port_nxt = '0;
      if (is_query) begin
        ok_nxt = (CMPW'(count_r) >= CMPW'(in_ports_wanted));
      end
      if (pop_en) begin
        ok_nxt    = 1'b1;
        head_nxt  = head_inc;
        count_nxt = count_r - 1'b1;
        // loaded ports still at the front come straight from the range
        if (left_r != '0) begin
          left_nxt       = left_r - 1'b1;
          range_port_nxt = low_r + PORT_W'(head_r);
        end else begin
          sel_mem_nxt = 1'b1;
        end
      end
      if (push_en) begin
        ok_nxt    = 1'b1;
        tail_nxt  = tail_inc;
        count_nxt = count_r + 1'b1;
      end
    end
  end

  assign fcnt_nxt = cmd.exec ? FCNT_W'(count_nxt) : fcnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r     <= RANGE_LOW_RST;
      high_r    <= RANGE_HIGH_RST;
      head_r    <= '0;
      tail_r    <= '0;
      count_r   <= '0;
      left_r    <= '0;
      ok_r      <= 1'b0;
      sel_mem_r <= 1'b0;
    end else begin
      low_r     <= low_nxt;
      high_r    <= high_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      count_r   <= count_nxt;
      left_r    <= left_nxt;
      ok_r      <= ok_nxt;
      sel_mem_r <= sel_mem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    range_port_r <= range_port_nxt;
    fcnt_r       <= fcnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      mem[tail_r] <= in_port_value;
    end
    if (pop_en) begin
      mem_q_r <= mem[head_r];
    end
  end

  assign out_ok         = ok_r;
  assign out_port_out   = sel_mem_r ? mem_q_r : range_port_r;
  assign out_free_count = fcnt_r;

  `PFLA_ASSERT_ALWAYS(a_count_max, count_r <= CW'(DEPTH), "free count above depth")
  `PFLA_ASSERT_ALWAYS(a_left_le_count, left_r <= count_r, "loaded ports exceed free count")
  `PFLA_ASSERT_NEXT(a_pop_dec, pop_en && !refill, count_r + 1'b1 == $past(count_r), "pop count")
  `PFLA_ASSERT_NEXT(a_push_inc, push_en && !refill, count_r == $past(count_r) + 1'b1, "push count")

endmodule
